// ----- src/slbsc_pkg.sv -----
// Shared types and constants of the single-line byte-state cache.
package slbsc_pkg;

    // Fixed field widths of the channels.
    localparam int ADDR_W = 8;
    localparam int BYTE_W = 8;
    localparam int ACTION_W = 2;
    localparam int KIND_W = 3;
    localparam int WIRE_BYTES = 8;
    localparam int LINE_W = WIRE_BYTES * BYTE_W;

    // Special address that invalidates on a load and flushes on a store.
    localparam logic [ADDR_W-1:0] ADDR_SPECIAL = 8'hFF;

    // Transaction actions.
    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPLETE = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CPU_DONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH_BYTE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH_LINE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STORE_BYTE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LINE_STORE = 3'd4;

    // Per-byte state of the line.
    typedef enum logic [1:0] {
        MARK_INVALID = 2'd0,
        MARK_VALID = 2'd1,
        MARK_WRITTEN = 2'd2
    } mark_t;

    // Outstanding memory request.
    typedef enum logic [1:0] {
        PEND_IDLE = 2'd0,
        PEND_FETCH = 2'd1,
        PEND_EVICT = 2'd2,
        PEND_FLUSH = 2'd3
    } pend_t;

    // Occupancy of the result register.
    typedef enum logic {
        OUT_EMPTY = 1'b0,
        OUT_FULL = 1'b1
    } out_state_t;

    // Line update requested from the datapath.
    typedef enum logic [2:0] {
        DP_NONE,
        DP_FILL,
        DP_EVICT_DONE,
        DP_FLUSH_DONE,
        DP_INVALIDATE,
        DP_STORE_HIT,
        DP_STORE_RETAG
    } dp_op_t;

    // Source of the result payload.
    typedef enum logic [2:0] {
        RES_DONE_ZERO,
        RES_DONE_HIT,
        RES_DONE_FILL,
        RES_FETCH_BYTE,
        RES_STORE_BYTE,
        RES_FETCH_LINE,
        RES_LINE_STORE
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        dp_op_t   op;
        res_sel_t res_sel;
        logic     load_result;
        logic     latch_pending;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_special;
        logic tag_hit;
        logic byte_live;
        logic line_live;
        logic line_dirty;
    } dp_status_t;

endpackage

// ----- src/slbsc_in_if.sv -----
// Channel that carries CPU accesses and memory completions into the cache.
interface slbsc_in_if;
    import slbsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   store_data;
    logic [LINE_W-1:0]   fetched_line;

    modport source (output valid, action, address, store_data, fetched_line, input ready);
    modport sink (input valid, action, address, store_data, fetched_line, output ready);
endinterface

// ----- src/slbsc_out_if.sv -----
// Channel that carries CPU answers and memory requests out of the cache.
interface slbsc_out_if;
    import slbsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [ADDR_W-1:0] mem_address;
    logic [BYTE_W-1:0] byte_value;
    logic [LINE_W-1:0] line_value;
    logic [BYTE_W-1:0] write_mask;

    modport source (output valid, result_kind, mem_address, byte_value, line_value,
                    write_mask, input ready);
    modport sink (input valid, result_kind, mem_address, byte_value, line_value,
                  write_mask, output ready);
endinterface

// ----- src/slbsc_ctrl.sv -----
// Controller: enable register, pending request, result register occupancy and decisions.
module slbsc_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          item_valid,
    input  logic [slbsc_pkg::ACTION_W-1:0] item_action,
    output logic                          item_ready,
    output logic                          result_valid,
    input  logic                          result_ready,
    input  slbsc_pkg::dp_status_t         status,
    output slbsc_pkg::ctl_cmd_t           cmd
);
    import slbsc_pkg::*;

    logic       enable_reg;
    pend_t      pend_reg;
    pend_t      pend_next;
    out_state_t state_reg;
    out_state_t state_next;
    logic       accept;
    logic       has_result;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            enable_reg <= cfg_wr_data;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_IDLE;
            state_reg <= OUT_EMPTY;
        end
        else
        begin
            pend_reg <= pend_next;
            state_reg <= state_next;
        end
    end

    // A new transaction is taken whenever the result register is free or drains now.
    assign item_ready = (state_reg == OUT_EMPTY) || result_ready;
    assign accept = item_valid && item_ready;
    assign result_valid = (state_reg == OUT_FULL);

    // Decision for the accepted transaction.
    always_comb
    begin
        pend_next = pend_reg;
        has_result = 1'b0;
        cmd.op = DP_NONE;
        cmd.res_sel = RES_DONE_ZERO;
        cmd.latch_pending = 1'b0;

        if (accept)
        begin
            if (!enable_reg)
            begin
                // Disabled: CPU accesses go straight to memory.
                if (item_action == ACT_LOAD)
                begin
                    has_result = 1'b1;
                    cmd.res_sel = RES_FETCH_BYTE;
                end
                else if (item_action == ACT_STORE)
                begin
                    has_result = 1'b1;
                    cmd.res_sel = RES_STORE_BYTE;
                end
            end
            else if (item_action == ACT_COMPLETE)
            begin
                if (pend_reg != PEND_IDLE)
                begin
                    pend_next = PEND_IDLE;
                    has_result = 1'b1;
                    unique case (pend_reg)
                        PEND_FETCH:
                        begin
                            cmd.op = DP_FILL;
                            cmd.res_sel = RES_DONE_FILL;
                        end
                        PEND_EVICT:
                        begin
                            cmd.op = DP_EVICT_DONE;
                        end
                        default:
                        begin
                            cmd.op = DP_FLUSH_DONE;
                        end
                    endcase
                end
            end
            else if (pend_reg == PEND_IDLE)
            begin
                if (item_action == ACT_LOAD)
                begin
                    has_result = 1'b1;
                    priority if (status.addr_special)
                    begin
                        cmd.op = DP_INVALIDATE;
                    end
                    else if (status.tag_hit && status.byte_live)
                    begin
                        cmd.res_sel = RES_DONE_HIT;
                    end
                    else
                    begin
                        pend_next = PEND_FETCH;
                        cmd.latch_pending = 1'b1;
                        cmd.res_sel = RES_FETCH_LINE;
                    end
                end
                else if (item_action == ACT_STORE)
                begin
                    has_result = 1'b1;
                    priority if (status.addr_special)
                    begin
                        if (status.line_live)
                        begin
                            pend_next = PEND_FLUSH;
                            cmd.latch_pending = 1'b1;
                            cmd.res_sel = RES_LINE_STORE;
                        end
                    end
                    else if (status.tag_hit)
                    begin
                        cmd.op = DP_STORE_HIT;
                    end
                    else if (!status.line_dirty)
                    begin
                        cmd.op = DP_STORE_RETAG;
                    end
                    else
                    begin
                        pend_next = PEND_EVICT;
                        cmd.latch_pending = 1'b1;
                        cmd.res_sel = RES_LINE_STORE;
                    end
                end
            end
        end

        cmd.load_result = has_result;

        // Result register occupancy.
        priority if (has_result)
        begin
            state_next = OUT_FULL;
        end
        else if (result_ready)
        begin
            state_next = OUT_EMPTY;
        end
        else
        begin
            state_next = state_reg;
        end
    end

endmodule

// ----- src/slbsc_dpath.sv -----
// Datapath: line storage, byte marks, pending request fields and result register.
module slbsc_dpath #(
    parameter int LINE_BYTES = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [slbsc_pkg::ADDR_W-1:0]     item_address,
    input  logic [slbsc_pkg::BYTE_W-1:0]     item_store_data,
    input  logic [slbsc_pkg::LINE_W-1:0]     item_fetched_line,
    input  slbsc_pkg::ctl_cmd_t              cmd,
    output slbsc_pkg::dp_status_t            status,
    output logic [slbsc_pkg::KIND_W-1:0]     result_kind,
    output logic [slbsc_pkg::ADDR_W-1:0]     mem_address,
    output logic [slbsc_pkg::BYTE_W-1:0]     byte_value,
    output logic [slbsc_pkg::LINE_W-1:0]     line_value,
    output logic [slbsc_pkg::BYTE_W-1:0]     write_mask
);
    import slbsc_pkg::*;

    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int TAG_W = $clog2((1 << ADDR_W) / LINE_BYTES);
    localparam int PACK_N = (LINE_BYTES < WIRE_BYTES) ? LINE_BYTES : WIRE_BYTES;

    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;
    logic [BYTE_W-1:0] bytes_reg [LINE_BYTES];
    logic [BYTE_W-1:0] bytes_next [LINE_BYTES];
    logic [BYTE_W-1:0] fill_bytes [LINE_BYTES];
    mark_t             marks_reg [LINE_BYTES];
    mark_t             marks_next [LINE_BYTES];
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [BYTE_W-1:0] pend_byte_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LINE_W-1:0] line_reg;
    logic [BYTE_W-1:0] mask_reg;
    logic [KIND_W-1:0] kind_next;
    logic [ADDR_W-1:0] addr_next;
    logic [BYTE_W-1:0] byte_next;
    logic [LINE_W-1:0] line_next;
    logic [BYTE_W-1:0] mask_next;

    logic [TAG_W-1:0]  item_tag;
    logic [OFF_W-1:0]  item_off;
    logic [TAG_W-1:0]  pend_tag;
    logic [OFF_W-1:0]  pend_off;
    logic [LINE_W-1:0] packed_line;
    logic [BYTE_W-1:0] dirty_mask;
    logic              any_valid;
    logic              any_written;

    // Address split of the incoming and the pending address.
    assign item_tag = TAG_W'(item_address / LINE_BYTES);
    assign item_off = OFF_W'(item_address % LINE_BYTES);
    assign pend_tag = TAG_W'(pend_addr_reg / LINE_BYTES);
    assign pend_off = OFF_W'(pend_addr_reg % LINE_BYTES);

    // Line summaries: packed bytes, written mask and mark presence.
    always_comb
    begin
        packed_line = '0;
        dirty_mask = '0;
        any_valid = 1'b0;
        any_written = 1'b0;
        for (int i = 0; i < PACK_N; i++)
        begin
            packed_line[i*BYTE_W +: BYTE_W] = bytes_reg[i];
            dirty_mask[i] = (marks_reg[i] == MARK_WRITTEN);
        end
        for (int i = 0; i < LINE_BYTES; i++)
        begin
            any_valid = any_valid || (marks_reg[i] == MARK_VALID);
            any_written = any_written || (marks_reg[i] == MARK_WRITTEN);
        end
    end

    // Line image loaded by a fetch completion; bytes past the wire width load as zero.
    always_comb
    begin
        for (int i = 0; i < LINE_BYTES; i++)
        begin
            fill_bytes[i] = '0;
        end
        for (int i = 0; i < PACK_N; i++)
        begin
            fill_bytes[i] = item_fetched_line[i*BYTE_W +: BYTE_W];
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.addr_special = (item_address == ADDR_SPECIAL);
        status.tag_hit = (item_tag == tag_reg);
        status.byte_live = (marks_reg[item_off] != MARK_INVALID);
        status.line_live = any_valid || any_written;
        status.line_dirty = any_written;
    end

    // Line update.
    always_comb
    begin
        tag_next = tag_reg;
        for (int i = 0; i < LINE_BYTES; i++)
        begin
            bytes_next[i] = bytes_reg[i];
            marks_next[i] = marks_reg[i];
        end
        unique case (cmd.op)
            DP_NONE:
            begin
            end
            DP_FILL:
            begin
                tag_next = pend_tag;
                for (int i = 0; i < LINE_BYTES; i++)
                begin
                    bytes_next[i] = fill_bytes[i];
                    marks_next[i] = MARK_VALID;
                end
            end
            DP_EVICT_DONE:
            begin
                tag_next = pend_tag;
                for (int i = 0; i < LINE_BYTES; i++)
                begin
                    marks_next[i] = MARK_INVALID;
                end
                bytes_next[pend_off] = pend_byte_reg;
                marks_next[pend_off] = MARK_WRITTEN;
            end
            DP_FLUSH_DONE:
            begin
                for (int i = 0; i < LINE_BYTES; i++)
                begin
                    if (marks_reg[i] == MARK_WRITTEN)
                    begin
                        marks_next[i] = MARK_VALID;
                    end
                end
            end
            DP_INVALIDATE:
            begin
                for (int i = 0; i < LINE_BYTES; i++)
                begin
                    marks_next[i] = MARK_INVALID;
                end
            end
            DP_STORE_HIT:
            begin
                bytes_next[item_off] = item_store_data;
                marks_next[item_off] = MARK_WRITTEN;
            end
            DP_STORE_RETAG:
            begin
                tag_next = item_tag;
                for (int i = 0; i < LINE_BYTES; i++)
                begin
                    marks_next[i] = MARK_INVALID;
                end
                bytes_next[item_off] = item_store_data;
                marks_next[item_off] = MARK_WRITTEN;
            end
            default:
            begin
            end
        endcase
    end

    // Result payload selection.
    always_comb
    begin
        kind_next = KIND_CPU_DONE;
        addr_next = '0;
        byte_next = '0;
        line_next = '0;
        mask_next = '0;
        unique case (cmd.res_sel)
            RES_DONE_ZERO:
            begin
            end
            RES_DONE_HIT:
            begin
                byte_next = bytes_reg[item_off];
            end
            RES_DONE_FILL:
            begin
                byte_next = fill_bytes[pend_off];
            end
            RES_FETCH_BYTE:
            begin
                kind_next = KIND_FETCH_BYTE;
                addr_next = item_address;
            end
            RES_STORE_BYTE:
            begin
                kind_next = KIND_STORE_BYTE;
                addr_next = item_address;
                byte_next = item_store_data;
            end
            RES_FETCH_LINE:
            begin
                kind_next = KIND_FETCH_LINE;
                addr_next = item_address - ADDR_W'(item_off);
            end
            RES_LINE_STORE:
            begin
                kind_next = KIND_LINE_STORE;
                addr_next = ADDR_W'(tag_reg * LINE_BYTES);
                line_next = packed_line;
                mask_next = dirty_mask;
            end
            default:
            begin
            end
        endcase
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
            for (int i = 0; i < LINE_BYTES; i++)
            begin
                bytes_reg[i] <= '0;
                marks_reg[i] <= MARK_INVALID;
            end
        end
        else
        begin
            tag_reg <= tag_next;
            for (int i = 0; i < LINE_BYTES; i++)
            begin
                bytes_reg[i] <= bytes_next[i];
                marks_reg[i] <= marks_next[i];
            end
        end
    end

    // Pending request fields and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_pending)
        begin
            pend_addr_reg <= item_address;
            pend_byte_reg <= item_store_data;
        end
        if (cmd.load_result)
        begin
            kind_reg <= kind_next;
            addr_reg <= addr_next;
            byte_reg <= byte_next;
            line_reg <= line_next;
            mask_reg <= mask_next;
        end
    end

    assign result_kind = kind_reg;
    assign mem_address = addr_reg;
    assign byte_value = byte_reg;
    assign line_value = line_reg;
    assign write_mask = mask_reg;

endmodule

// ----- src/single_line_byte_state_cache_top.sv -----
// Top level of the single-line byte-state write-back cache.
// One transaction is accepted per clock cycle: the decision for a CPU load, a CPU store or a
// memory completion is made in the cycle it is accepted, and its result (CPU answer or memory
// request) appears in the result register on the next cycle. The result register sets the
// rate: item.ready drops only while that register holds a result that result.ready has not
// taken, so with a free output side the sustained rate is one transaction per cycle; a
// transaction without a result leaves the output alone. The user must write the enable
// register through cfg_wr_en and cfg_wr_data only while the cache is idle (not enforced).
module single_line_byte_state_cache_top #(
    parameter int LINE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    slbsc_in_if.sink    item,
    slbsc_out_if.source result
);
    import slbsc_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Controller.
    slbsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item.valid),
        .item_action  (item.action),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath.
    slbsc_dpath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_address      (item.address),
        .item_store_data   (item.store_data),
        .item_fetched_line (item.fetched_line),
        .cmd               (cmd),
        .status            (status),
        .result_kind       (result.result_kind),
        .mem_address       (result.mem_address),
        .byte_value        (result.byte_value),
        .line_value        (result.line_value),
        .write_mask        (result.write_mask)
    );

endmodule
